// ===== src/svpc_pkg.sv =====
// Shared types, constants and the sine table for the space-vector PWM compare block.
// No dependencies; used by svpc_front, svpc_back and space_vector_pwm_compare.
package svpc_pkg;

    localparam int MAG_W      = 13;  // magnitude input width
    localparam int ANGLE_W    = 16;  // angle input width
    localparam int CMP_W      = 15;  // compare output width
    localparam int HALF_W     = 12;  // half period register width
    localparam int ROM_W      = 16;  // sine table word width
    localparam int FRAC_W     = 8;   // fraction within a sector
    localparam int PROD_W     = (MAG_W + 1) + (ROM_W + 1);  // signed product width
    localparam int SHIFT      = 16;  // floor shift after multiply
    localparam int TABLE_ENTRIES = 257;

    localparam logic [HALF_W-1:0] HALF_PERIOD_RST = HALF_W'(249);

    // Sub-sector pattern after folding the upper three sectors onto the lower three
    typedef enum logic [1:0] {
        SUB_0 = 2'd0,
        SUB_1 = 2'd1,
        SUB_2 = 2'd2
    } t_sub;

    // Handoff from the multiply stage to the combine stage
    typedef struct packed {
        t_sub                      sub;
        logic signed [PROD_W-1:0]  dy_prod;
        logic signed [PROD_W-1:0]  dx_prod;
    } t_prod;

    // sin(0..60 deg) scaled so that 65536 is 1.0
    localparam logic [ROM_W-1:0] SINE_ROM [0:TABLE_ENTRIES-1] = '{
        16'd0, 16'd268, 16'd536, 16'd804, 16'd1072, 16'd1340, 16'd1608, 16'd1876,
        16'd2144, 16'd2412, 16'd2680, 16'd2947, 16'd3215, 16'd3483, 16'd3751, 16'd4018,
        16'd4286, 16'd4553, 16'd4821, 16'd5088, 16'd5355, 16'd5622, 16'd5889, 16'd6156,
        16'd6423, 16'd6690, 16'd6957, 16'd7223, 16'd7489, 16'd7756, 16'd8022, 16'd8288,
        16'd8554, 16'd8819, 16'd9085, 16'd9350, 16'd9616, 16'd9881, 16'd10146, 16'd10410,
        16'd10675, 16'd10939, 16'd11204, 16'd11468, 16'd11732, 16'd11995, 16'd12259,
        16'd12522, 16'd12785, 16'd13048, 16'd13310, 16'd13573, 16'd13835, 16'd14097,
        16'd14359, 16'd14620, 16'd14881, 16'd15142, 16'd15403, 16'd15663, 16'd15923,
        16'd16183, 16'd16443, 16'd16702, 16'd16961, 16'd17220, 16'd17479, 16'd17737,
        16'd17995, 16'd18253, 16'd18510, 16'd18767, 16'd19024, 16'd19280, 16'd19536,
        16'd19792, 16'd20047, 16'd20302, 16'd20557, 16'd20811, 16'd21065, 16'd21319,
        16'd21572, 16'd21825, 16'd22078, 16'd22330, 16'd22582, 16'd22833, 16'd23085,
        16'd23335, 16'd23586, 16'd23836, 16'd24085, 16'd24334, 16'd24583, 16'd24831,
        16'd25079, 16'd25327, 16'd25574, 16'd25820, 16'd26066, 16'd26312, 16'd26557,
        16'd26802, 16'd27047, 16'd27291, 16'd27534, 16'd27777, 16'd28020, 16'd28262,
        16'd28503, 16'd28745, 16'd28985, 16'd29226, 16'd29465, 16'd29704, 16'd29943,
        16'd30181, 16'd30419, 16'd30656, 16'd30893, 16'd31129, 16'd31365, 16'd31600,
        16'd31834, 16'd32069, 16'd32302, 16'd32535, 16'd32767, 16'd32999, 16'd33231,
        16'd33462, 16'd33692, 16'd33921, 16'd34150, 16'd34379, 16'd34607, 16'd34834,
        16'd35061, 16'd35287, 16'd35513, 16'd35738, 16'd35962, 16'd36186, 16'd36409,
        16'd36632, 16'd36854, 16'd37075, 16'd37296, 16'd37516, 16'd37736, 16'd37955,
        16'd38173, 16'd38390, 16'd38607, 16'd38824, 16'd39039, 16'd39254, 16'd39469,
        16'd39682, 16'd39895, 16'd40108, 16'd40319, 16'd40530, 16'd40741, 16'd40950,
        16'd41159, 16'd41368, 16'd41575, 16'd41782, 16'd41988, 16'd42194, 16'd42398,
        16'd42602, 16'd42806, 16'd43008, 16'd43210, 16'd43412, 16'd43612, 16'd43812,
        16'd44011, 16'd44209, 16'd44407, 16'd44603, 16'd44799, 16'd44995, 16'd45189,
        16'd45383, 16'd45576, 16'd45768, 16'd45960, 16'd46150, 16'd46340, 16'd46530,
        16'd46718, 16'd46906, 16'd47092, 16'd47279, 16'd47464, 16'd47648, 16'd47832,
        16'd48015, 16'd48197, 16'd48378, 16'd48558, 16'd48738, 16'd48917, 16'd49095,
        16'd49272, 16'd49448, 16'd49624, 16'd49799, 16'd49972, 16'd50146, 16'd50318,
        16'd50489, 16'd50660, 16'd50829, 16'd50998, 16'd51166, 16'd51333, 16'd51499,
        16'd51665, 16'd51829, 16'd51993, 16'd52155, 16'd52317, 16'd52478, 16'd52639,
        16'd52798, 16'd52956, 16'd53114, 16'd53270, 16'd53426, 16'd53581, 16'd53735,
        16'd53888, 16'd54040, 16'd54191, 16'd54341, 16'd54491, 16'd54639, 16'd54787,
        16'd54933, 16'd55079, 16'd55224, 16'd55368, 16'd55511, 16'd55653, 16'd55794,
        16'd55934, 16'd56073, 16'd56212, 16'd56349, 16'd56485, 16'd56621, 16'd56755
    };

endpackage

// ===== src/svpc_front.sv =====
// Input register, sector split, sine lookups and the two magnitude multiplies.
// Depends on svpc_pkg; feeds svpc_back through a t_prod register.
module svpc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [svpc_pkg::MAG_W-1:0]   i_magnitude,
    input  logic        [svpc_pkg::ANGLE_W-1:0] i_angle,
    output logic                                o_valid,
    input  logic                                i_ready,
    output svpc_pkg::t_prod                     o_prod
);
    import svpc_pkg::*;

    logic                      r_in_valid;
    logic signed [MAG_W-1:0]   r_mag;
    logic        [ANGLE_W-1:0] r_angle;
    logic                      r_prod_valid;
    t_prod                     r_prod;

    logic                      w_prod_ready;
    logic                      w_in_ready;
    logic [ANGLE_W+2:0]        w_angle6;
    logic [2:0]                w_sector;
    logic [FRAC_W-1:0]         w_frac;
    logic [FRAC_W:0]           w_frac_c;
    logic                      w_neg;
    logic signed [MAG_W:0]     w_mag_ext;
    logic signed [MAG_W:0]     w_mag_adj;
    logic signed [ROM_W:0]     w_k_dy;
    logic signed [ROM_W:0]     w_k_dx;
    t_prod                     n_prod;

    assign w_prod_ready = !r_prod_valid || i_ready;
    assign w_in_ready   = !r_in_valid || w_prod_ready;
    assign o_ready      = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_valid;
        end
        if (w_in_ready && i_valid) begin
            r_mag   <= i_magnitude;
            r_angle <= i_angle;
        end
    end

    always_comb begin
        // angle * 6 as (angle << 2) + (angle << 1)
        w_angle6  = {1'b0, r_angle, 2'b00} + {2'b00, r_angle, 1'b0};
        w_sector  = w_angle6[ANGLE_W+2:ANGLE_W];
        w_frac    = w_angle6[ANGLE_W-1:ANGLE_W-FRAC_W];
        w_frac_c  = (FRAC_W+1)'(TABLE_ENTRIES - 1) - {1'b0, w_frac};
        w_neg     = (w_sector >= 3'd3);
        w_mag_ext = {r_mag[MAG_W-1], r_mag};
        w_mag_adj = w_neg ? -w_mag_ext : w_mag_ext;
        w_k_dy    = {1'b0, SINE_ROM[w_frac]};
        w_k_dx    = {1'b0, SINE_ROM[w_frac_c]};
        n_prod.dy_prod = w_mag_adj * w_k_dy;
        n_prod.dx_prod = w_mag_adj * w_k_dx;
        case (w_sector)
            3'd0, 3'd3: n_prod.sub = SUB_0;
            3'd1, 3'd4: n_prod.sub = SUB_1;
            default:    n_prod.sub = SUB_2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_valid <= 1'b0;
        end else if (w_prod_ready) begin
            r_prod_valid <= r_in_valid;
        end
        if (w_prod_ready && r_in_valid) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_prod_valid;
    assign o_prod  = r_prod;

endmodule

// ===== src/svpc_back.sv =====
// Floor shift of the products, sum and difference, and placement around the half period.
// Depends on svpc_pkg; holds the result register of the block.
module svpc_back (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  svpc_pkg::t_prod                         i_prod,
    input  logic        [svpc_pkg::HALF_W-1:0]      i_half_period,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [svpc_pkg::CMP_W-1:0]       o_compare_a,
    output logic signed [svpc_pkg::CMP_W-1:0]       o_compare_b,
    output logic signed [svpc_pkg::CMP_W-1:0]       o_compare_c
);
    import svpc_pkg::*;

    localparam int SUM_W = PROD_W - SHIFT + 1;

    logic                    r_valid;
    logic signed [CMP_W-1:0] r_a;
    logic signed [CMP_W-1:0] r_b;
    logic signed [CMP_W-1:0] r_c;

    logic                    w_ready;
    logic signed [SUM_W-2:0] w_dy;
    logic signed [SUM_W-2:0] w_dx;
    logic signed [SUM_W-1:0] w_s;
    logic signed [SUM_W-1:0] w_d;
    logic signed [SUM_W-1:0] w_h;
    logic signed [SUM_W-1:0] w_a;
    logic signed [SUM_W-1:0] w_b;
    logic signed [SUM_W-1:0] w_c;

    assign w_ready = !r_valid || i_ready;
    assign o_ready = w_ready;

    always_comb begin
        // arithmetic shift of a signed product is a floor division
        w_dy = (SUM_W-1)'(i_prod.dy_prod >>> SHIFT);
        w_dx = (SUM_W-1)'(i_prod.dx_prod >>> SHIFT);
        w_s  = SUM_W'(w_dx) + SUM_W'(w_dy);
        w_d  = SUM_W'(w_dx) - SUM_W'(w_dy);
        w_h  = SUM_W'(signed'({1'b0, i_half_period}));
        case (i_prod.sub)
            SUB_0: begin
                w_a = w_h - w_s;
                w_b = w_h + w_d;
                w_c = w_h + w_s;
            end
            SUB_1: begin
                w_a = w_h - w_d;
                w_b = w_h - w_s;
                w_c = w_h + w_s;
            end
            default: begin
                w_a = w_h + w_s;
                w_b = w_h - w_s;
                w_c = w_h + w_d;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
        if (w_ready && i_valid) begin
            r_a <= w_a[CMP_W-1:0];
            r_b <= w_b[CMP_W-1:0];
            r_c <= w_c[CMP_W-1:0];
        end
    end

    assign o_valid     = r_valid;
    assign o_compare_a = r_a;
    assign o_compare_b = r_b;
    assign o_compare_c = r_c;

endmodule

// ===== src/space_vector_pwm_compare.sv =====
// Space-vector PWM compare generator, top level: half period register and the pipeline.
// Depends on svpc_pkg, svpc_front and svpc_back.
//
// Takes one item per clock while not stalled (a signed magnitude and a 16-bit electrical
// angle) and returns three centre-aligned compare values for phases A, B and C, one result
// item per input item. The angle times six picks one of six 60-degree sectors and an
// 8-bit fraction; two sine-table lookups scaled by the magnitude and floor-shifted by 16
// give the two vector components, whose sum and difference are placed around half_period.
// Results are two's complement and not clamped: a magnitude beyond plus or minus
// half_period can give compare values outside 0..2*half_period. Throughput is one item
// per cycle while not stalled. Three registers sit on the path (input register, product
// register, result register): the input register loads at the accepting edge, and the
// item then passes through the product register to the result register, which drives
// o_valid. The multipliers sit between the input and product registers. Both sides
// stall independently; every stage holds its item while the next is full and stalled.
// half_period resets to 249 and is written through i_cfg_we / i_cfg_wdata; write it only
// while no item is in flight.
module space_vector_pwm_compare (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic        [svpc_pkg::HALF_W-1:0]      i_cfg_wdata,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic signed [svpc_pkg::MAG_W-1:0]       i_magnitude,
    input  logic        [svpc_pkg::ANGLE_W-1:0]     i_angle,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [svpc_pkg::CMP_W-1:0]       o_compare_a,
    output logic signed [svpc_pkg::CMP_W-1:0]       o_compare_b,
    output logic signed [svpc_pkg::CMP_W-1:0]       o_compare_c
);
    import svpc_pkg::*;

    logic [HALF_W-1:0] r_half_period;
    logic              w_prod_valid;
    logic              w_prod_ready;
    t_prod             w_prod;

    // hold the half period; the user must write it only while the pipeline is empty, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
        end else if (i_cfg_we) begin
            r_half_period <= i_cfg_wdata;
        end
    end

    // sector split, table lookups and multiplies
    svpc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_magnitude (i_magnitude),
        .i_angle     (i_angle),
        .o_valid     (w_prod_valid),
        .i_ready     (w_prod_ready),
        .o_prod      (w_prod)
    );

    // floor shift, sum and difference, placement around the half period
    svpc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_prod_valid),
        .o_ready       (w_prod_ready),
        .i_prod        (w_prod),
        .i_half_period (r_half_period),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_compare_a   (o_compare_a),
        .o_compare_b   (o_compare_b),
        .o_compare_c   (o_compare_c)
    );

endmodule
